// ----- design/rbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rbpm_pkg
// Shared types and constants of the robust burst pixel merge.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpm_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);

  localparam int VAL_W = 32;   // Q24.8 sample value
  localparam int WGT_W = 16;   // Q2.14 weight
  localparam int ACC_W = 52;   // sum of value * weight
  localparam int WSUM_W = 20;  // sum of weights

  localparam logic [14:0] Q14_ONE     = 15'd16384;
  localparam logic [15:0] MIN_WEIGHT  = 16'd164;
  localparam logic [35:0] GATE_FLOOR  = 36'd12288;  // 48.0 in Q24.8

  // register indexes
  localparam logic [2:0] REG_BLACK0 = 3'd0;
  localparam logic [2:0] REG_BLACK1 = 3'd1;
  localparam logic [2:0] REG_BLACK2 = 3'd2;
  localparam logic [2:0] REG_BLACK3 = 3'd3;
  localparam logic [2:0] REG_WHITE  = 3'd4;

  typedef enum logic [2:0] {
    WG_IDLE, WG_PREP, WG_DIV, WG_MUL1, WG_MUL2, WG_DONE
  } wgt_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COND, ST_MED1, ST_MED2, ST_DEV, ST_MAD1, ST_MAD2,
    ST_GATE, ST_SUM, ST_DRAIN, ST_QSET, ST_QDIV, ST_FIN
  } rbpm_state_t;

  typedef struct packed {
    logic load;  // shift a new sample in from the lower neighbor
    logic rot;   // rotate toward cell 0
    logic ins;   // insert into the sorted key row
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/rbpm_cell.sv -----
// ----------------------------------------------------------------------------
// rbpm_cell
// One cell of the sample row: stored value, weight, deviation and one
// slot of the sorted key row.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpm_cell (
  input  wire logic                clk,
  input  wire rbpm_pkg::cell_ctl_t ctl,
  input  wire logic [31:0]         load_val,
  input  wire logic [15:0]         load_wgt,
  input  wire logic [31:0]         rot_val,
  input  wire logic [15:0]         rot_wgt,
  input  wire logic [31:0]         rot_dev,
  input  wire logic [31:0]         ins_x,
  input  wire logic [31:0]         prev_key,
  input  wire logic                prev_gt,
  input  wire logic                occupied,
  output logic [31:0]              val,
  output logic [15:0]              wgt,
  output logic [31:0]              dev,
  output logic [31:0]              key,
  output logic                     gt
);

  // free slots count as larger than anything
  assign gt = !occupied || (key > ins_x);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= load_val;
      wgt <= load_wgt;
    end else if (ctl.rot) begin
      val <= rot_val;
      wgt <= rot_wgt;
      dev <= rot_dev;
    end
    if (ctl.ins && gt) begin
      key <= prev_gt ? prev_key : ins_x;
    end
  end

endmodule

`default_nettype wire

// ----- design/rbpm_wgt.sv -----
// ----------------------------------------------------------------------------
// rbpm_wgt
// Sample conditioning: black subtract, exposure scale, shadow and
// highlight confidence (bit-serial divides), weight.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpm_wgt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] raw,
  input  wire logic [15:0] black,
  input  wire logic [15:0] white,
  input  wire logic [23:0] scale,
  input  wire logic [14:0] fw,
  output logic             done,
  output logic [31:0]      val,
  output logic [15:0]      wgt
);

  rbpm_pkg::wgt_state_t state, state_next;

  logic [15:0] signal, range_r;
  logic [15:0] rem_sh;
  logic [17:0] rem_hi, div_hi;
  logic [13:0] q_sh, q_hi;
  logic        sat_sh, sat_hi;
  logic [3:0]  cnt;
  logic [14:0] w1;

  logic [15:0] sig_c, rng_c, sclip_c, dif_c;
  logic [20:0] s25_c, d25_c;
  logic [17:0] d3_c;
  logic [16:0] t_sh;
  logic [18:0] t_hi;
  logic [14:0] sh_c, hi_c;
  logic [29:0] p1_c, p2_c;
  logic [40:0] v_c;
  logic [15:0] wv_c;

  always_comb begin
    sig_c   = (raw > black) ? 16'(raw - black) : 16'd0;
    rng_c   = (white > black) ? 16'(white - black) : 16'd1;
    sclip_c = (sig_c < rng_c) ? sig_c : rng_c;
    dif_c   = 16'(rng_c - sclip_c);
    s25_c   = 21'(sig_c) * 21'd25;
    d25_c   = 21'(dif_c) * 21'd25;
    d3_c    = 18'(rng_c) * 18'd3;
    t_sh    = {rem_sh, 1'b0};
    t_hi    = {rem_hi, 1'b0};
    sh_c    = sat_sh ? rbpm_pkg::Q14_ONE : {1'b0, q_sh};
    hi_c    = sat_hi ? rbpm_pkg::Q14_ONE : {1'b0, q_hi};
    p1_c    = 30'(sh_c) * 30'(hi_c);
    p2_c    = 30'(w1) * 30'(fw);
    v_c     = 41'(signal) * 41'(scale) + 41'd128;
    wv_c    = p2_c[29:14];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rbpm_pkg::WG_IDLE: if (start) state_next = rbpm_pkg::WG_PREP;
      rbpm_pkg::WG_PREP: state_next = rbpm_pkg::WG_DIV;
      rbpm_pkg::WG_DIV:  if (cnt == 4'd13) state_next = rbpm_pkg::WG_MUL1;
      rbpm_pkg::WG_MUL1: state_next = rbpm_pkg::WG_MUL2;
      rbpm_pkg::WG_MUL2: state_next = rbpm_pkg::WG_DONE;
      rbpm_pkg::WG_DONE: state_next = rbpm_pkg::WG_IDLE;
      default:           state_next = rbpm_pkg::WG_IDLE;
    endcase
  end

  always_comb begin
    done = (state == rbpm_pkg::WG_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbpm_pkg::WG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rbpm_pkg::WG_PREP: begin
        signal  <= sig_c;
        range_r <= rng_c;
        div_hi  <= d3_c;
        sat_sh  <= s25_c >= 21'(rng_c);
        sat_hi  <= d25_c >= 21'(d3_c);
        rem_sh  <= s25_c[15:0];
        rem_hi  <= d25_c[17:0];
        cnt     <= 4'd0;
      end
      rbpm_pkg::WG_DIV: begin
        if (t_sh >= {1'b0, range_r}) begin
          rem_sh <= 16'(t_sh - {1'b0, range_r});
          q_sh   <= {q_sh[12:0], 1'b1};
        end else begin
          rem_sh <= t_sh[15:0];
          q_sh   <= {q_sh[12:0], 1'b0};
        end
        if (t_hi >= {1'b0, div_hi}) begin
          rem_hi <= 18'(t_hi - {1'b0, div_hi});
          q_hi   <= {q_hi[12:0], 1'b1};
        end else begin
          rem_hi <= t_hi[17:0];
          q_hi   <= {q_hi[12:0], 1'b0};
        end
        cnt <= 4'(cnt + 4'd1);
      end
      rbpm_pkg::WG_MUL1: begin
        w1  <= p1_c[28:14];
        val <= v_c[39:8];
      end
      rbpm_pkg::WG_MUL2: begin
        wgt <= (wv_c < rbpm_pkg::MIN_WEIGHT) ? rbpm_pkg::MIN_WEIGHT : wv_c;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/rbpm_div.sv -----
// ----------------------------------------------------------------------------
// rbpm_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [51:0] num,
  input  wire logic [19:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [19:0] rem;
  logic [31:0] nlo;
  logic [20:0] t;
  logic        ge;

  // caller guarantees num[51:32] < den, so the quotient fits 32 bits
  assign t  = {rem, nlo[31]};
  assign ge = t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[51:32];
      nlo <= num[31:0];
      cnt <= 5'd0;
    end else if (busy) begin
      rem <= ge ? 20'(t - {1'b0, den}) : t[19:0];
      nlo <= {nlo[30:0], 1'b0};
      quo <= {quo[30:0], ge};
      cnt <= 5'(cnt + 5'd1);
    end
  end

endmodule

`default_nettype wire

// ----- design/robust_burst_pixel_merge.sv -----
// ----------------------------------------------------------------------------
// robust_burst_pixel_merge
// Median/MAD gated weighted merge of one Bayer pixel over a burst.
// ----------------------------------------------------------------------------
// One request is one frame's sample of the pixel. Each sample passes
// through the conditioning unit (the bit-serial shadow/highlight
// divides), and the next request is taken only after it is done. The
// sample then enters a row of 16 cells: an arrival row (value, weight,
// deviation) and an insertion-sorted key row. A request with tlast
// closes the pixel: median read (MED1, MED2), a rotation of the row
// computing deviations and sorting them, MAD read (MAD1, MAD2), gate,
// a rotation accumulating value*weight of the kept samples plus a drain
// step, a divider setup step, the 32-bit divide and its done flag, and
// a final step to add black, round and clamp. When no weight passes the
// gate, the divide is skipped and the median is used. Samples beyond 16
// are dropped without the conditioning pass; tlast on one still closes.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only happen while the block is idle. The result sits in an output
// register, so the next pixel's first request is taken while it waits.
`default_nettype none

module robust_burst_pixel_merge (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // sample requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // sample_value[15:0], energy_scale[39:16],
                                          // frame_weight[54:40], zero pad[55]
  input  wire logic [1:0]  s_axis_tuser,  // site[1:0]
  input  wire logic        s_axis_tlast,  // last_sample
  // merged pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // merged_pixel[15:0]
);

  localparam int N = rbpm_pkg::MAX_SAMPLES;

  rbpm_pkg::rbpm_state_t state, state_next;

  // config registers
  logic [15:0] black [4];
  logic [15:0] white;
  logic [15:0] white_eff;

  // captured request
  logic [15:0] raw_r;
  logic [1:0]  site_r;
  logic [23:0] scale_r;
  logic [14:0] fw_r;
  logic        last_r;

  logic [rbpm_pkg::CNT_W-1:0] count, sortn;
  logic [rbpm_pkg::IDX_W-1:0] k;

  logic [31:0] pick, med, mad, mean;
  logic [35:0] gate;
  logic [47:0] prod;
  logic [15:0] prod_w;
  logic        pv;
  logic [rbpm_pkg::ACC_W-1:0]  vsum;
  logic [rbpm_pkg::WSUM_W-1:0] wsum;

  logic [15:0] out_data;
  logic        out_valid;

  logic accept, wstart, wdone, dstart, ddone, fire;
  logic [31:0] w_val;
  logic [15:0] w_wgt;
  logic [31:0] quo;

  rbpm_pkg::cell_ctl_t ctl;
  logic [31:0] c_val [N];
  logic [15:0] c_wgt [N];
  logic [31:0] c_dev [N];
  logic [31:0] c_key [N];
  logic        c_gt  [N];

  logic [31:0] dev_c, ins_x, rd_key, mid_c;
  logic [rbpm_pkg::IDX_W-1:0] hi_idx, lo_idx, rd_idx;
  logic [35:0] gate9_c;
  logic        keep_c;
  logic [32:0] tot_c;
  logic [15:0] black_sel;

  assign cfg_ready = 1'b1;
  assign white_eff = (white == 16'd0) ? 16'd1 : white;
  assign black_sel = black[site_r];
  assign accept    = s_axis_tvalid && s_axis_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      black[0] <= 16'd0;
      black[1] <= 16'd0;
      black[2] <= 16'd0;
      black[3] <= 16'd0;
      white    <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbpm_pkg::REG_BLACK0: black[0] <= cfg_data;
        rbpm_pkg::REG_BLACK1: black[1] <= cfg_data;
        rbpm_pkg::REG_BLACK2: black[2] <= cfg_data;
        rbpm_pkg::REG_BLACK3: black[3] <= cfg_data;
        rbpm_pkg::REG_WHITE:  white    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------- sample conditioning ----------------
  rbpm_wgt u_wgt (
    .clk   (clk),
    .rst   (rst),
    .start (wstart),
    .raw   (raw_r),
    .black (black_sel),
    .white (white_eff),
    .scale (scale_r),
    .fw    (fw_r),
    .done  (wdone),
    .val   (w_val),
    .wgt   (w_wgt)
  );

  // ---------------- cell row ----------------
  always_comb begin
    dev_c  = (c_val[0] > med) ? 32'(c_val[0] - med) : 32'(med - c_val[0]);
    ins_x  = (state == rbpm_pkg::ST_DEV) ? dev_c : w_val;
    hi_idx = count[rbpm_pkg::CNT_W-1:1];
    lo_idx = rbpm_pkg::IDX_W'(hi_idx - 1'b1);
    rd_idx = (state == rbpm_pkg::ST_MED2 || state == rbpm_pkg::ST_MAD2) ? lo_idx : hi_idx;
    rd_key = c_key[rd_idx];
    // odd count: middle key; even: floor of mean of the two middle keys
    mid_c  = count[0] ? pick : 32'(({1'b0, rd_key} + {1'b0, pick}) >> 1);
    gate9_c = (36'(mad) * 36'd9) >> 1;
    keep_c = ({1'b0, k} < count) && ({4'd0, c_dev[0]} <= gate);
    tot_c  = 33'(mean) + 33'({black_sel, 8'h80});
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic [31:0] lv, rv, rd, pk;
      logic [15:0] lw, rw;
      logic        pg;
      if (gi == 0) begin : g_first
        assign lv = w_val;
        assign lw = w_wgt;
        assign pk = 32'd0;
        assign pg = 1'b0;
      end else begin : g_mid
        assign lv = c_val[gi-1];
        assign lw = c_wgt[gi-1];
        assign pk = c_key[gi-1];
        assign pg = c_gt[gi-1];
      end
      if (gi == N - 1) begin : g_last
        assign rv = c_val[0];
        assign rw = c_wgt[0];
        assign rd = (state == rbpm_pkg::ST_DEV) ? dev_c : c_dev[0];
      end else begin : g_body
        assign rv = c_val[gi+1];
        assign rw = c_wgt[gi+1];
        assign rd = c_dev[gi+1];
      end
      rbpm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .load_val (lv),
        .load_wgt (lw),
        .rot_val  (rv),
        .rot_wgt  (rw),
        .rot_dev  (rd),
        .ins_x    (ins_x),
        .prev_key (pk),
        .prev_gt  (pg),
        .occupied (rbpm_pkg::CNT_W'(gi) < sortn),
        .val      (c_val[gi]),
        .wgt      (c_wgt[gi]),
        .dev      (c_dev[gi]),
        .key      (c_key[gi]),
        .gt       (c_gt[gi])
      );
    end
  endgenerate

  // ---------------- mean divider ----------------
  function automatic logic [rbpm_pkg::ACC_W-1:0] ACC_SUM(
    input logic [rbpm_pkg::ACC_W-1:0]  v,
    input logic [rbpm_pkg::WSUM_W-1:0] w
  );
    ACC_SUM = v + rbpm_pkg::ACC_W'(w >> 1);
  endfunction

  rbpm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (ACC_SUM(vsum, wsum)),
    .den   (wsum),
    .done  (ddone),
    .quo   (quo)
  );

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      rbpm_pkg::ST_IDLE: begin
        if (accept) begin
          if (count < rbpm_pkg::CNT_W'(N)) state_next = rbpm_pkg::ST_COND;
          else if (s_axis_tlast)           state_next = rbpm_pkg::ST_MED1;
        end
      end
      rbpm_pkg::ST_COND: begin
        if (wdone) state_next = last_r ? rbpm_pkg::ST_MED1 : rbpm_pkg::ST_IDLE;
      end
      rbpm_pkg::ST_MED1:  state_next = rbpm_pkg::ST_MED2;
      rbpm_pkg::ST_MED2:  state_next = rbpm_pkg::ST_DEV;
      rbpm_pkg::ST_DEV:   if (k == rbpm_pkg::IDX_W'(N - 1)) state_next = rbpm_pkg::ST_MAD1;
      rbpm_pkg::ST_MAD1:  state_next = rbpm_pkg::ST_MAD2;
      rbpm_pkg::ST_MAD2:  state_next = rbpm_pkg::ST_GATE;
      rbpm_pkg::ST_GATE:  state_next = rbpm_pkg::ST_SUM;
      rbpm_pkg::ST_SUM:   if (k == rbpm_pkg::IDX_W'(N - 1)) state_next = rbpm_pkg::ST_DRAIN;
      rbpm_pkg::ST_DRAIN: state_next = rbpm_pkg::ST_QSET;
      rbpm_pkg::ST_QSET:  state_next = (wsum == '0) ? rbpm_pkg::ST_FIN : rbpm_pkg::ST_QDIV;
      rbpm_pkg::ST_QDIV:  if (ddone) state_next = rbpm_pkg::ST_FIN;
      rbpm_pkg::ST_FIN:   if (fire) state_next = rbpm_pkg::ST_IDLE;
      default:            state_next = rbpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == rbpm_pkg::ST_IDLE);
    wstart   = accept && (count < rbpm_pkg::CNT_W'(N));
    dstart   = (state == rbpm_pkg::ST_QSET) && (wsum != '0);
    fire     = (state == rbpm_pkg::ST_FIN) && (!out_valid || m_axis_tready);
    ctl.load = (state == rbpm_pkg::ST_COND) && wdone;
    ctl.rot  = (state == rbpm_pkg::ST_DEV) || (state == rbpm_pkg::ST_SUM);
    ctl.ins  = ((state == rbpm_pkg::ST_COND) && wdone) ||
               ((state == rbpm_pkg::ST_DEV) && ({1'b0, k} < count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbpm_pkg::ST_IDLE;
      count     <= '0;
      sortn     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
        count     <= '0;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (ctl.load) count <= rbpm_pkg::CNT_W'(count + 1'b1);
      if (state == rbpm_pkg::ST_MED2) sortn <= '0;
      else if (ctl.ins)               sortn <= rbpm_pkg::CNT_W'(sortn + 1'b1);
      if (fire) sortn <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r   <= s_axis_tdata[15:0];
      scale_r <= s_axis_tdata[39:16];
      fw_r    <= s_axis_tdata[54:40];
      site_r  <= s_axis_tuser;
      last_r  <= s_axis_tlast;
    end
    if (state == rbpm_pkg::ST_MED1 || state == rbpm_pkg::ST_MAD1) pick <= rd_key;
    if (state == rbpm_pkg::ST_MED2) begin
      med <= mid_c;
      k   <= '0;
    end
    if (state == rbpm_pkg::ST_DEV || state == rbpm_pkg::ST_SUM) k <= rbpm_pkg::IDX_W'(k + 1'b1);
    if (state == rbpm_pkg::ST_MAD2) mad <= mid_c;
    if (state == rbpm_pkg::ST_GATE) begin
      gate <= (gate9_c < rbpm_pkg::GATE_FLOOR) ? rbpm_pkg::GATE_FLOOR : gate9_c;
      k    <= '0;
      vsum <= '0;
      wsum <= '0;
      pv   <= 1'b0;
    end
    if (state == rbpm_pkg::ST_SUM) begin
      prod   <= 48'(c_val[0]) * 48'(c_wgt[0]);
      prod_w <= c_wgt[0];
      pv     <= keep_c;
    end
    if ((state == rbpm_pkg::ST_SUM || state == rbpm_pkg::ST_DRAIN) && pv) begin
      vsum <= rbpm_pkg::ACC_W'(vsum + rbpm_pkg::ACC_W'(prod));
      wsum <= rbpm_pkg::WSUM_W'(wsum + rbpm_pkg::WSUM_W'(prod_w));
    end
    if (state == rbpm_pkg::ST_QSET && wsum == '0) mean <= med;
    if (state == rbpm_pkg::ST_QDIV && ddone)       mean <= quo;
    if (fire) begin
      out_data <= (tot_c[32:8] > 25'(white_eff)) ? white_eff : tot_c[23:8];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rbpm_pkg::CNT_W'(N))
    else $error("sample count beyond row depth");

  a_sort_bound: assert property (@(posedge clk) disable iff (rst)
    sortn <= count)
    else $error("sorted row holds more than stored samples");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == rbpm_pkg::ST_FIN))
    else $error("result raised outside finish step");

  a_wdone_cond: assert property (@(posedge clk) disable iff (rst)
    wdone |-> state == rbpm_pkg::ST_COND)
    else $error("conditioning finished while not waiting for it");

endmodule

`default_nettype wire

// ----- sim/tb_robust_burst_pixel_merge.sv -----
// ----------------------------------------------------------------------------
// tb_robust_burst_pixel_merge
// Self-checking bench: random and directed pixel bursts against a merge model.
// ----------------------------------------------------------------------------
// The initial block queues sample requests (pixels of 1..20 frames, the
// last marked by tlast) and register writes between phases. A clocked
// driver feeds the requests at the falling edge with random idle bursts; a
// clocked monitor takes merged pixels at the rising edge with random
// stalls and compares them with the expected-pixel queue that the merge
// model fills as each request is accepted.
`default_nettype none

module tb_robust_burst_pixel_merge;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 150;

  typedef struct {
    logic [15:0] raw;
    logic [1:0]  site;
    logic [23:0] scale;
    logic [14:0] fweight;
    logic        last;
  } sample_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  robust_burst_pixel_merge dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Merge model: own copy of registers and per-pixel stores
  // ---------------------------------------------------------------------------
  logic [15:0] mdl_black [4];
  logic [15:0] mdl_white;
  logic [31:0] mdl_vals [rbpm_pkg::MAX_SAMPLES];
  logic [15:0] mdl_wgts [rbpm_pkg::MAX_SAMPLES];
  int          mdl_count;

  logic [15:0] expected_pixels[$];
  sample_req_t pending_reqs[$];
  int          error_count = 0;
  bit          quiet_mode = 1'b0;   // no idling in the last part
  bit          all_queued = 1'b0;
  int          watchdog = 0;

  task automatic model_reset();
    for (int i = 0; i < 4; i++) mdl_black[i] = '0;
    mdl_white = 16'hFFFF;
    mdl_count = 0;
  endtask

  function automatic logic [31:0] median_u32(logic [31:0] src[rbpm_pkg::MAX_SAMPLES], int n);
    logic [31:0] t[$];
    for (int i = 0; i < n; i++) t.push_back(src[i]);
    t.sort();
    if (n == 0) return 0;
    if (n % 2) return t[n/2];
    return 32'(({1'b0, t[n/2-1]} + {1'b0, t[n/2]}) >> 1);
  endfunction

  // Conditions one accepted request; pushes the merged pixel on tlast.
  task automatic merge_sample(sample_req_t r);
    logic [16:0] w_eff, b, sig, rng, sclip;
    logic [63:0] val, sh, hi, w, gate, wsum, vsum, mean, total;
    logic [31:0] med, mad;
    logic [31:0] devs[rbpm_pkg::MAX_SAMPLES];
    w_eff = (mdl_white == 0) ? 17'd1 : {1'b0, mdl_white};
    b = {1'b0, mdl_black[r.site]};
    if (mdl_count < rbpm_pkg::MAX_SAMPLES) begin
      sig = (r.raw > b) ? ({1'b0, r.raw} - b) : 17'd0;
      rng = (w_eff > b) ? (w_eff - b) : 17'd1;
      sclip = (sig < rng) ? sig : rng;
      val = (64'(sig) * 64'(r.scale) + 64'd128) >> 8;
      sh = (64'd25 * 64'(sig) * 64'd16384) / 64'(rng);
      hi = (64'd25 * 64'(rng - sclip) * 64'd16384) / (64'd3 * 64'(rng));
      if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
      if (sh > 64'd16384) sh = 64'd16384;
      if (hi > 64'd16384) hi = 64'd16384;
      w = (sh * hi) >> 14;
      w = (w * 64'(r.fweight)) >> 14;
      if (w < 64'd164) w = 64'd164;
      mdl_vals[mdl_count] = val[31:0];
      mdl_wgts[mdl_count] = w[15:0];
      mdl_count++;
    end
    if (!r.last) return;
    med = median_u32(mdl_vals, mdl_count);
    for (int i = 0; i < mdl_count; i++)
      devs[i] = (mdl_vals[i] > med) ? mdl_vals[i] - med : med - mdl_vals[i];
    mad = median_u32(devs, mdl_count);
    gate = (64'(mad) * 64'd9) >> 1;
    if (gate < 64'd12288) gate = 64'd12288;
    wsum = 0;
    vsum = 0;
    for (int i = 0; i < mdl_count; i++) begin
      if (64'(devs[i]) > gate) continue;
      vsum += 64'(mdl_vals[i]) * 64'(mdl_wgts[i]);
      wsum += 64'(mdl_wgts[i]);
    end
    mean = (wsum > 0) ? (vsum + wsum / 2) / wsum : 64'(med);
    total = (mean + (64'(b) << 8) + 64'd128) >> 8;
    if (total > 64'(w_eff)) total = 64'(w_eff);
    expected_pixels.push_back(total[15:0]);
    mdl_count = 0;
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: changes at falling edge, acceptance judged at rising edge
  // ---------------------------------------------------------------------------
  int  src_idle = 0;
  bit  s_fire;
  bit  s_taken = 1'b0;   // request accepted at the last rising edge
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always @(posedge clk) begin
    s_taken <= !rst && s_fire;
    if (!rst && s_fire) begin
      sample_req_t r;
      r.raw = s_axis_tdata[15:0];
      r.scale = s_axis_tdata[39:16];
      r.fweight = s_axis_tdata[54:40];
      r.site = s_axis_tuser;
      r.last = s_axis_tlast;
      merge_sample(r);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_taken) begin
      // hold the request
    end else if (src_idle > 0) begin
      src_idle <= src_idle - 1;
      s_axis_tvalid <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      src_idle <= $urandom_range(0, 4);
      s_axis_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      sample_req_t r;
      r = pending_reqs.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {1'b0, r.fweight, r.scale, r.raw};
      s_axis_tuser <= r.site;
      s_axis_tlast <= r.last;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor with random stalls
  // ---------------------------------------------------------------------------
  int sink_stall = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected merged pixel %0d", m_axis_tdata));
      end else begin
        logic [15:0] exp_px;
        exp_px = expected_pixels.pop_front();
        if (m_axis_tdata !== exp_px)
          report_mismatch($sformatf("merged_pixel got %0d want %0d", m_axis_tdata,
                                    exp_px));
      end
    end
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if (rst || s_fire || (m_axis_tvalid && m_axis_tready) || all_queued &&
        pending_reqs.size() == 0 && !s_axis_tvalid && expected_pixels.size() == 0) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("robust_burst_pixel_merge verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= rbpm_pkg::REG_BLACK3) mdl_black[idx[1:0]] = value;
    else if (idx == rbpm_pkg::REG_WHITE) mdl_white = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets the block fall idle before a register write.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_req_t rand_sample(bit last);
    sample_req_t r;
    r.raw = 16'($urandom);
    r.site = 2'($urandom);
    case ($urandom_range(0, 3))
      0: r.scale = 24'h010000;
      1: r.scale = 24'($urandom_range(24'h008000, 24'h040000));
      default: r.scale = 24'($urandom);
    endcase
    r.fweight = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(8000, 16384));
    r.last = last;
    return r;
  endfunction

  // One pixel burst: mostly a cluster with a few outliers.
  task automatic queue_pixel(int frames);
    logic [15:0] base;
    logic [1:0]  site;
    sample_req_t r;
    base = 16'($urandom);
    site = 2'($urandom);
    for (int i = 0; i < frames; i++) begin
      r = rand_sample(i == frames - 1);
      if ($urandom_range(0, 4) != 0) begin
        r.raw = 16'(int'(base) + $urandom_range(0, 200) - 100);
        r.site = site;
        r.scale = 24'h010000;
      end
      pending_reqs.push_back(r);
    end
  endtask

  function automatic sample_req_t mk(logic [15:0] raw, logic [1:0] site,
                                     logic [23:0] scale, logic [14:0] fw, bit last);
    sample_req_t r;
    r.raw = raw; r.site = site; r.scale = scale; r.fweight = fw; r.last = last;
    return r;
  endfunction

  initial begin
    int items;
    int frames;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, single-sample pixel, store overflow.
    pending_reqs.push_back(mk(16'h0000, 2'd0, 24'h000000, 15'h0000, 1'b1));
    pending_reqs.push_back(mk(16'hFFFF, 2'd3, 24'hFFFFFF, 15'h7FFF, 1'b1));
    pending_reqs.push_back(mk(16'h8000, 2'd1, 24'h010000, 15'h4000, 1'b0));
    pending_reqs.push_back(mk(16'h1234, 2'd2, 24'h800000, 15'h2AAA, 1'b1));
    // Store full: 20 samples, the last beyond the store still closes.
    for (int i = 0; i < 20; i++)
      pending_reqs.push_back(mk(16'(1000 + i * 300), 2'(i), 24'h010000, 15'h3000, i == 19));
    wait_drained();

    // Black above white, white level zero, unknown index.
    write_reg(rbpm_pkg::REG_BLACK0, 16'd5000);
    write_reg(rbpm_pkg::REG_BLACK1, 16'hFFFF);
    write_reg(rbpm_pkg::REG_BLACK2, 16'd64);
    write_reg(rbpm_pkg::REG_BLACK3, 16'd1023);
    write_reg(rbpm_pkg::REG_WHITE, 16'd0);
    write_reg(3'd7, 16'hABCD);
    queue_pixel(3);
    queue_pixel(4);
    wait_drained();
    write_reg(rbpm_pkg::REG_WHITE, 16'd4095);
    queue_pixel(1);
    queue_pixel(16);
    wait_drained();

    // Random phases with fresh register settings.
    items = 0;
    while (items < 540) begin
      for (int k = 0; k < 5; k++) begin
        case ($urandom_range(0, 3))
          0: write_reg(3'(k), (k == rbpm_pkg::REG_WHITE) ? 16'hFFFF : 16'h0000);
          1: write_reg(3'(k), (k == rbpm_pkg::REG_WHITE) ? 16'd1 : 16'hFFFF);
          default: write_reg(3'(k), (k == rbpm_pkg::REG_WHITE)
                                    ? 16'($urandom_range(1000, 65535))
                                    : 16'($urandom_range(0, 4000)));
        endcase
      end
      for (int p = 0; p < 6; p++) begin
        frames = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                             : $urandom_range(1, 12);
        queue_pixel(frames);
        items += frames;
      end
      if (items > 430) quiet_mode = 1'b1;
      wait_drained();
    end

    all_queued = 1'b1;
    wait_drained();
    if (error_count == 0) begin
      $display("robust_burst_pixel_merge verification clean");
    end else begin
      $display("robust_burst_pixel_merge verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/rbpm_pkg.sv
design/rbpm_cell.sv
design/rbpm_wgt.sv
design/rbpm_div.sv
design/robust_burst_pixel_merge.sv
sim/tb_robust_burst_pixel_merge.sv
